>>> src/bpa_pkg.sv
// Shared types and constants for the buddy page allocator.
// Holds field widths, status codes, datapath commands and controller status.
// Depends on nothing; every other file of the block but bpa_ram uses it.
package bpa_pkg;

    // Fixed field widths
    localparam int CNT_W  = 13;
    localparam int ORD_W  = 4;
    localparam int PIDX_W = 12;
    localparam int ST_W   = 2;
    localparam int CHK_W  = 18;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFREE  = 2'd1;
    localparam logic [ST_W-1:0] ST_BADFREE = 2'd2;

    // Item function codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Datapath commands issued by the controller
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_UNL_RD,
        CMD_UNL_WR,
        CMD_TOG_RD,
        CMD_TOG_WR,
        CMD_DEC,
        CMD_PUSH_A,
        CMD_PUSH_B
    } dp_cmd_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic is_free;
        logic ok;
        logic lvl_gt_ord;
        logic can_merge;
        logic bit_old;
        logic clr_done;
    } dp_stat_t;

endpackage

>>> src/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for link tables and the buddy pair bitmap; no package dependency.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/bpa_ctrl.sv
// Controller state machine of the buddy page allocator.
// Sequences datapath commands; uses bpa_pkg for command and status types.
module bpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bpa_pkg::dp_stat_t stat,
    output bpa_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              done
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_UNL_RD,
        S_UNL_WR,
        S_FCHK,
        S_TOG_RD,
        S_TOG_WR,
        S_DEC,
        S_PUSH_A,
        S_PUSH_B,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (stat.clr_done) state_next = S_IDLE;
            S_IDLE:   if (start) state_next = S_EVAL;
            S_EVAL:
            begin
                if (!stat.ok)
                    state_next = S_DONE;
                else if (stat.is_free)
                    state_next = S_FCHK;
                else
                    state_next = S_UNL_RD;
            end
            S_UNL_RD: state_next = S_UNL_WR;
            S_UNL_WR: state_next = stat.is_free ? S_FCHK : S_TOG_RD;
            S_FCHK:   state_next = stat.can_merge ? S_TOG_RD : S_PUSH_A;
            S_TOG_RD: state_next = S_TOG_WR;
            S_TOG_WR:
            begin
                if (stat.is_free)
                    state_next = stat.bit_old ? S_UNL_RD : S_PUSH_A;
                else
                    state_next = stat.lvl_gt_ord ? S_DEC : S_DONE;
            end
            S_DEC:    state_next = S_PUSH_A;
            S_PUSH_A: state_next = S_PUSH_B;
            S_PUSH_B: state_next = stat.is_free ? S_DONE : S_TOG_RD;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Hold state; clear the bitmap after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode command for the datapath
    always_comb
    begin
        unique case (state_reg)
            S_CLEAR:  cmd = bpa_pkg::CMD_CLEAR;
            S_IDLE:   cmd = start ? bpa_pkg::CMD_LOAD : bpa_pkg::CMD_NONE;
            S_UNL_RD: cmd = bpa_pkg::CMD_UNL_RD;
            S_UNL_WR: cmd = bpa_pkg::CMD_UNL_WR;
            S_TOG_RD: cmd = bpa_pkg::CMD_TOG_RD;
            S_TOG_WR: cmd = bpa_pkg::CMD_TOG_WR;
            S_DEC:    cmd = bpa_pkg::CMD_DEC;
            S_PUSH_A: cmd = bpa_pkg::CMD_PUSH_A;
            S_PUSH_B: cmd = bpa_pkg::CMD_PUSH_B;
            default:  cmd = bpa_pkg::CMD_NONE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

>>> src/bpa_dp.sv
// Datapath of the buddy page allocator: free-list heads, link RAMs,
// buddy pair bitmap RAM and free page count. Uses bpa_pkg and bpa_ram.
module bpa_dp #(
    parameter int PAGES  = 4096,
    parameter int ORDERS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpa_pkg::dp_cmd_t              cmd,
    output bpa_pkg::dp_stat_t             stat,
    input  logic                          func,
    input  logic [bpa_pkg::ORD_W-1:0]     order,
    input  logic [bpa_pkg::PIDX_W-1:0]    page_index,
    input  logic [bpa_pkg::CNT_W-1:0]     low_watermark,
    input  logic [bpa_pkg::CNT_W-1:0]     zone_pages,
    output logic [bpa_pkg::ST_W-1:0]      status,
    output logic [bpa_pkg::PIDX_W-1:0]    page_index_out,
    output logic [bpa_pkg::CNT_W-1:0]     free_count
);

    localparam int PW   = $clog2(PAGES);
    localparam int LW   = PW + 1;
    localparam int OW   = (ORDERS > 2) ? $clog2(ORDERS) : 1;
    localparam int BA_W = OW + PW - 1;
    localparam logic [LW-1:0] LINK_NONE = '1;
    localparam logic [LW-1:0] PAGES_L   = LW'(PAGES);

    // State registers
    logic [LW-1:0]             head_reg [ORDERS];
    logic [bpa_pkg::CNT_W-1:0] free_reg;
    logic [BA_W-1:0]           clr_reg;
    logic                      func_reg;
    logic [bpa_pkg::ORD_W-1:0] ord_reg;
    logic [OW-1:0]             lvl_reg;
    logic [PW-1:0]             blk_reg;
    logic                      ok_reg;
    logic                      split_reg;
    logic [bpa_pkg::ST_W-1:0]  status_reg;

    // RAM ports
    logic            next_we, prev_we, bit_we, link_re, bit_re;
    logic [PW-1:0]   next_waddr, prev_waddr, link_raddr;
    logic [LW-1:0]   next_wdata, prev_wdata, next_rd, prev_rd;
    logic [BA_W-1:0] bit_waddr, bit_addr;
    logic            bit_wdata, bit_rd;

    // Load-time evaluation
    logic [bpa_pkg::CHK_W-1:0] size, pidx_ext, limit;
    logic                      free_bad, found, alloc_ok;
    logic [OW-1:0]             found_lvl;
    logic [PW-1:0]             mask, unl_node;
    logic [LW-1:0]             head_cur;

    assign size     = bpa_pkg::CHK_W'(1) << order;
    assign pidx_ext = bpa_pkg::CHK_W'(page_index);
    assign limit    = (bpa_pkg::CHK_W'(zone_pages) > bpa_pkg::CHK_W'(PAGES))
                      ? bpa_pkg::CHK_W'(PAGES) : bpa_pkg::CHK_W'(zone_pages);
    assign free_bad = (int'(order) >= ORDERS) ||
                      ((pidx_ext & (size - 1'b1)) != '0) ||
                      (pidx_ext + size > limit);

    // Find the lowest non-empty list at or above the requested order
    always_comb
    begin
        found     = 1'b0;
        found_lvl = '0;
        for (int i = ORDERS - 1; i >= 0; i--)
        begin
            if (i >= int'(order) && head_reg[i] < PAGES_L)
            begin
                found     = 1'b1;
                found_lvl = OW'(i);
            end
        end
    end

    assign alloc_ok   = found && (free_reg >= low_watermark);
    assign mask       = PW'(1) << lvl_reg;
    assign unl_node   = func_reg ? (blk_reg ^ mask) : blk_reg;
    assign head_cur   = head_reg[lvl_reg];
    assign bit_addr   = {lvl_reg, (PW-1)'((blk_reg >> 1) >> lvl_reg)};
    assign link_raddr = unl_node;

    // Drive RAM ports from the command
    always_comb
    begin
        next_we    = 1'b0;
        next_waddr = blk_reg;
        next_wdata = head_cur;
        prev_we    = 1'b0;
        prev_waddr = blk_reg;
        prev_wdata = LINK_NONE;
        link_re    = 1'b0;
        bit_we     = 1'b0;
        bit_waddr  = bit_addr;
        bit_wdata  = ~bit_rd;
        bit_re     = 1'b0;
        case (cmd)
            bpa_pkg::CMD_CLEAR:
            begin
                bit_we    = 1'b1;
                bit_waddr = clr_reg;
                bit_wdata = 1'b0;
            end
            bpa_pkg::CMD_UNL_RD: link_re = 1'b1;
            bpa_pkg::CMD_UNL_WR:
            begin
                next_we    = (prev_rd < PAGES_L);
                next_waddr = prev_rd[PW-1:0];
                next_wdata = next_rd;
                prev_we    = (next_rd < PAGES_L);
                prev_waddr = next_rd[PW-1:0];
                prev_wdata = prev_rd;
            end
            bpa_pkg::CMD_TOG_RD: bit_re = 1'b1;
            bpa_pkg::CMD_TOG_WR: bit_we = 1'b1;
            bpa_pkg::CMD_PUSH_A:
            begin
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            bpa_pkg::CMD_PUSH_B:
            begin
                prev_we    = (head_cur < PAGES_L);
                prev_waddr = head_cur[PW-1:0];
                prev_wdata = LW'(blk_reg);
            end
            default: ;
        endcase
    end

    // Heads, free count and clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORDERS; i++)
            begin
                head_reg[i] <= LINK_NONE;
            end
            free_reg <= '0;
            clr_reg  <= '0;
        end
        else
        begin
            case (cmd)
                bpa_pkg::CMD_CLEAR: clr_reg <= clr_reg + 1'b1;
                bpa_pkg::CMD_LOAD:
                begin
                    if (!func && alloc_ok)
                        free_reg <= free_reg - bpa_pkg::CNT_W'(size);
                    else if (func && !free_bad)
                        free_reg <= free_reg + bpa_pkg::CNT_W'(size);
                end
                bpa_pkg::CMD_UNL_WR:
                begin
                    if (!(prev_rd < PAGES_L))
                        head_reg[lvl_reg] <= next_rd;
                end
                bpa_pkg::CMD_PUSH_B: head_reg[lvl_reg] <= LW'(blk_reg);
                default: ;
            endcase
        end
    end

    // Operation registers
    always_ff @(posedge clk)
    begin
        case (cmd)
            bpa_pkg::CMD_LOAD:
            begin
                func_reg  <= func;
                ord_reg   <= order;
                split_reg <= 1'b0;
                if (!func)
                begin
                    ok_reg     <= alloc_ok;
                    lvl_reg    <= found_lvl;
                    blk_reg    <= head_reg[found_lvl][PW-1:0];
                    status_reg <= alloc_ok ? bpa_pkg::ST_OK : bpa_pkg::ST_NOFREE;
                end
                else
                begin
                    ok_reg     <= !free_bad;
                    lvl_reg    <= OW'(order);
                    blk_reg    <= PW'(page_index);
                    status_reg <= free_bad ? bpa_pkg::ST_BADFREE : bpa_pkg::ST_OK;
                end
            end
            bpa_pkg::CMD_UNL_WR:
            begin
                // Merge with the buddy and climb one order
                if (func_reg)
                begin
                    blk_reg <= blk_reg & ~mask;
                    lvl_reg <= lvl_reg + 1'b1;
                end
            end
            bpa_pkg::CMD_TOG_WR:
            begin
                // Advance to the upper half after a split
                if (!func_reg && split_reg)
                    blk_reg <= blk_reg + mask;
            end
            bpa_pkg::CMD_DEC:
            begin
                lvl_reg   <= lvl_reg - 1'b1;
                split_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    bpa_ram #(.WIDTH(LW), .DEPTH(PAGES)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (next_rd)
    );

    bpa_ram #(.WIDTH(LW), .DEPTH(PAGES)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (prev_rd)
    );

    bpa_ram #(.WIDTH(1), .DEPTH(2 ** BA_W)) u_bit_ram (
        .clk   (clk),
        .we    (bit_we),
        .waddr (bit_waddr),
        .wdata (bit_wdata),
        .re    (bit_re),
        .raddr (bit_addr),
        .rdata (bit_rd)
    );

    // Status toward the controller
    assign stat.is_free    = func_reg;
    assign stat.ok         = ok_reg;
    assign stat.lvl_gt_ord = bpa_pkg::ORD_W'(lvl_reg) > ord_reg;
    assign stat.can_merge  = lvl_reg < OW'(ORDERS - 1);
    assign stat.bit_old    = bit_rd;
    assign stat.clr_done   = &clr_reg;

    // Result beat
    assign status         = status_reg;
    assign page_index_out = (!func_reg && ok_reg) ? bpa_pkg::PIDX_W'(blk_reg) : '0;
    assign free_count     = free_reg;

endmodule

>>> src/buddy_page_allocator_top.sv
// Buddy page allocator: one item at a time. An allocate unlinks the block found, then
// splits it down to the asked order, pushing each lower half onto its list and toggling
// pair bits; a free toggles pair bits, unlinks each free buddy and climbs an order, then
// pushes the merged block; a refused item goes straight to done. The next start is taken
// the cycle after done. After reset the bitmap RAM is cleared, one entry a cycle, busy high:
// ORDERS rounded up to a power of two times PAGES/2 entries (32768 here).
module buddy_page_allocator_top #(
    parameter int PAGES  = 4096,
    parameter int ORDERS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       func,
    input  logic [bpa_pkg::ORD_W-1:0]  order,
    input  logic [bpa_pkg::PIDX_W-1:0] page_index,
    output logic                       done,
    output logic [bpa_pkg::ST_W-1:0]   status,
    output logic [bpa_pkg::PIDX_W-1:0] page_index_out,
    output logic [bpa_pkg::CNT_W-1:0]  free_count,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam logic REG_LWM  = 1'b0;
    localparam logic REG_ZONE = 1'b1;

    logic [bpa_pkg::CNT_W-1:0] lwm_reg, zone_reg;
    logic                      cfg_wr;
    bpa_pkg::dp_cmd_t          cmd;
    bpa_pkg::dp_stat_t         stat;

    // Configuration register writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lwm_reg  <= '0;
            zone_reg <= 13'd4096;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_LWM:  lwm_reg  <= pwdata[bpa_pkg::CNT_W-1:0];
                REG_ZONE: zone_reg <= pwdata[bpa_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[2])
            REG_LWM:  prdata = 32'(lwm_reg);
            REG_ZONE: prdata = 32'(zone_reg);
            default:  prdata = '0;
        endcase
    end

    bpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    bpa_dp #(.PAGES(PAGES), .ORDERS(ORDERS)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .func           (func),
        .order          (order),
        .page_index     (page_index),
        .low_watermark  (lwm_reg),
        .zone_pages     (zone_reg),
        .status         (status),
        .page_index_out (page_index_out),
        .free_count     (free_count)
    );

endmodule

>>> src/bpa_checker.sv
// Port-level checks for the buddy page allocator top level.
// Uses bpa_pkg for widths and status codes; bound to the top below.
module bpa_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [bpa_pkg::ST_W-1:0]   status,
    input logic [bpa_pkg::PIDX_W-1:0] page_index_out
);

    // One result beat per item, never two in a row
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted item did not occupy the block");

    // The result beat is shown while the block is still busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // Status stays in its defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == bpa_pkg::ST_OK || status == bpa_pkg::ST_NOFREE ||
                  status == bpa_pkg::ST_BADFREE))
        else $error("undefined status code");

    // A refused item reports page zero
    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != bpa_pkg::ST_OK) |-> (page_index_out == '0))
        else $error("refused item reported a page");

endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .page_index_out (page_index_out)
);

>>> test/buddy_page_allocator_checker.sv
// Checker for the buddy page allocator: watches the command, result and APB ports.
// Keeps its own free lists, pair bits and free count, and compares every result.
// Depends on bpa_pkg for field widths, function and status codes.
module buddy_page_allocator_checker #(
    parameter logic [2:0] REG_LWM  = 3'd0,
    parameter logic [2:0] REG_ZONE = 3'd4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       func,
    input  logic [bpa_pkg::ORD_W-1:0]  order,
    input  logic [bpa_pkg::PIDX_W-1:0] page_index,
    input  logic                       done,
    input  logic [bpa_pkg::ST_W-1:0]   status,
    input  logic [bpa_pkg::PIDX_W-1:0] page_index_out,
    input  logic [bpa_pkg::CNT_W-1:0]  free_count,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,
    output int                         fails,
    output int                         pending
);

    localparam int NPAGES  = 4096;
    localparam int NORDERS = 10;

    typedef struct {
        logic [bpa_pkg::ST_W-1:0]   st;
        logic [bpa_pkg::PIDX_W-1:0] pg;
        logic [bpa_pkg::CNT_W-1:0]  cnt;
    } alloc_result_t;

    alloc_result_t expected_q[$];

    int                        link_next [NPAGES];
    int                        link_prev [NPAGES];
    int                        list_top  [NORDERS];
    bit                        pair_bit  [NORDERS][NPAGES/2];
    logic [bpa_pkg::CNT_W-1:0] pages_free;
    logic [bpa_pkg::CNT_W-1:0] watermark;
    logic [bpa_pkg::CNT_W-1:0] zone_size;

    function automatic bit flip_pair(int k, int blk);
        int i;
        bit old;
        i = blk >> (k + 1);
        old = pair_bit[k][i];
        pair_bit[k][i] = ~old;
        return old;
    endfunction

    function automatic void list_insert(int k, int node);
        int h;
        h = list_top[k];
        link_next[node] = h;
        link_prev[node] = -1;
        if (h >= 0)
            link_prev[h] = node;
        list_top[k] = node;
    endfunction

    function automatic void list_remove(int k, int node);
        int p;
        int n;
        p = link_prev[node];
        n = link_next[node];
        if (p >= 0)
            link_next[p] = n;
        else
            list_top[k] = n;
        if (n >= 0)
            link_prev[n] = p;
    endfunction

    // Work out the result of one accepted command and update the allocator copy
    function automatic alloc_result_t predict_buddy(logic f,
                                                    logic [bpa_pkg::ORD_W-1:0] ord,
                                                    logic [bpa_pkg::PIDX_W-1:0] pidx);
        alloc_result_t r;
        int c;
        int blk;
        int lim;
        bit found;
        r.st = bpa_pkg::ST_OK;
        r.pg = '0;
        found = 0;
        c = ord;
        lim = (zone_size > NPAGES) ? NPAGES : int'(zone_size);
        if (f == bpa_pkg::FUNC_ALLOC)
        begin
            if (pages_free >= watermark)
            begin
                for (c = ord; c < NORDERS; c++)
                    if (list_top[c] >= 0)
                    begin
                        found = 1;
                        break;
                    end
            end
            if (!found)
                r.st = bpa_pkg::ST_NOFREE;
            else
            begin
                blk = list_top[c];
                list_remove(c, blk);
                void'(flip_pair(c, blk));
                pages_free = pages_free - bpa_pkg::CNT_W'(1 << ord);
                while (c > ord)
                begin
                    c--;
                    list_insert(c, blk);
                    void'(flip_pair(c, blk));
                    blk += 1 << c;
                end
                r.pg = bpa_pkg::PIDX_W'(blk);
            end
        end
        else if (ord >= NORDERS || (int'(pidx) & ((1 << ord) - 1)) != 0
                 || int'(pidx) + (1 << ord) > lim)
        begin
            r.st = bpa_pkg::ST_BADFREE;
        end
        else
        begin
            c = ord;
            blk = pidx;
            pages_free = pages_free + bpa_pkg::CNT_W'(1 << ord);
            while (c + 1 < NORDERS)
            begin
                if (!flip_pair(c, blk))
                    break;
                list_remove(c, blk ^ (1 << c));
                blk &= ~(1 << c);
                c++;
            end
            list_insert(c, blk);
        end
        r.cnt = pages_free;
        return r;
    endfunction

    // Track register writes, predict accepted commands, compare result beats
    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t e;
        if (!rst_n)
        begin
            expected_q.delete();
            fails = 0;
            for (int k = 0; k < NORDERS; k++)
                list_top[k] = -1;
            foreach (pair_bit[k, i])
                pair_bit[k][i] = 0;
            pages_free = '0;
            watermark = '0;
            zone_size = bpa_pkg::CNT_W'(NPAGES);
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == REG_LWM)
                    watermark = pwdata[bpa_pkg::CNT_W-1:0];
                else if (paddr == REG_ZONE)
                    zone_size = pwdata[bpa_pkg::CNT_W-1:0];
            end
            if (start && !busy)
                expected_q.push_back(predict_buddy(func, order, page_index));
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fails++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (status !== e.st)
                    begin
                        $error("status: expected %0d, got %0d", e.st, status);
                        fails++;
                    end
                    if (page_index_out !== e.pg)
                    begin
                        $error("page_index_out: expected %0d, got %0d",
                               e.pg, page_index_out);
                        fails++;
                    end
                    if (free_count !== e.cnt)
                    begin
                        $error("free_count: expected %0d, got %0d", e.cnt, free_count);
                        fails++;
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

>>> test/tb_buddy_page_allocator_top.sv
// Testbench top for the buddy page allocator: clock, reset, commands and APB writes.
// Frees only blocks it holds, or deliberately bad ones; the checker does the comparing.
// Depends on bpa_pkg, buddy_page_allocator_top and buddy_page_allocator_checker.
module tb_buddy_page_allocator_top;

    localparam logic [2:0] REG_LWM  = 3'd0;
    localparam logic [2:0] REG_ZONE = 3'd4;
    localparam int   CYCLE_LIMIT = 3000000;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       func;
    logic [bpa_pkg::ORD_W-1:0]  order;
    logic [bpa_pkg::PIDX_W-1:0] page_index;
    logic                       done;
    logic [bpa_pkg::ST_W-1:0]   status;
    logic [bpa_pkg::PIDX_W-1:0] page_index_out;
    logic [bpa_pkg::CNT_W-1:0]  free_count;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    int                         fails;
    int                         pending;
    int                         cmds_sent;
    int                         results_seen;
    int                         cycles;
    int                         zone_now;
    bit                         quiet;

    // blocks currently owned by the testbench, safe to free
    int held_page[$];
    int held_ord[$];

    buddy_page_allocator_top i_dut (.*);

    buddy_page_allocator_checker #(.REG_LWM(REG_LWM), .REG_ZONE(REG_ZONE)) i_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Count result beats and guard against a hang
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results_seen <= 0;
        else if (done)
            results_seen <= results_seen + 1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] addr, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (addr == REG_ZONE)
            zone_now = value;
    endtask

    // Hold start until the beat is taken; start stays high for the caller
    task automatic issue(logic f, int ord, int pidx);
        start      <= 1'b1;
        func       <= f;
        order      <= bpa_pkg::ORD_W'(ord);
        page_index <= bpa_pkg::PIDX_W'(pidx);
        do
            @(posedge clk);
        while (busy);
        cmds_sent++;
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (results_seen != cmds_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Allocate and keep the returned block when it succeeds
    task automatic alloc_block(int ord, int pidx);
        issue(bpa_pkg::FUNC_ALLOC, ord, pidx);
        start <= 1'b0;
        do
            @(posedge clk);
        while (!done);
        if (status == bpa_pkg::ST_OK && ord < 10)
        begin
            held_page.push_back(page_index_out);
            held_ord.push_back(ord);
        end
    endtask

    // Free a held block; drop it only when it lies inside the zone
    task automatic free_held(int idx);
        int p;
        int o;
        p = held_page[idx];
        o = held_ord[idx];
        if (p + (1 << o) <= zone_now)
        begin
            held_page.delete(idx);
            held_ord.delete(idx);
        end
        issue(bpa_pkg::FUNC_FREE, o, p);
    endtask

    // Free that must be refused: order too large or misaligned
    task automatic free_bad();
        int o;
        int p;
        o = $urandom_range(0, 15);
        p = $urandom_range(0, 4095);
        if (o >= 10 || o == 0)
            o = $urandom_range(10, 15);
        else
            p = p | (1 << $urandom_range(0, o - 1));
        issue(bpa_pkg::FUNC_FREE, o, p);
    endtask

    task automatic random_cmd();
        int r;
        int o;
        r = $urandom_range(0, 99);
        if (r < 45 || (r < 88 && held_page.size() == 0))
        begin
            o = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
            alloc_block(o, $urandom_range(0, 4095));
        end
        else if (r < 88)
            free_held($urandom_range(0, held_page.size() - 1));
        else
            free_bad();
        if (!quiet && $urandom_range(0, 3) == 0)
            pause($urandom_range(1, 16));
    endtask

    initial
    begin
        int p;
        int o;
        int lwm_set[7];
        int zone_set[7];
        lwm_set  = '{13'd4096, 100, 0, 0, 0, 8, 0};
        zone_set = '{13'd4096, 4096, 1, 2500, 4096, 4096, 4096};
        cmds_sent = 0;
        zone_now = 4096;
        quiet = 0;
        rst_n = 1'b0;
        start = 1'b0;
        func = bpa_pkg::FUNC_ALLOC;
        order = '0;
        page_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        // The whole zone starts allocated: first 512 pages as single pages,
        // the rest cut into random aligned blocks
        for (p = 0; p < 512; p++)
        begin
            held_page.push_back(p);
            held_ord.push_back(0);
        end
        while (p < 4096)
        begin
            o = $urandom_range(0, 9);
            while ((p & ((1 << o) - 1)) != 0)
                o--;
            held_page.push_back(p);
            held_ord.push_back(o);
            p += 1 << o;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        reg_write(REG_LWM, 0);
        reg_write(REG_ZONE, 4096);

        // Directed: empty store, oversized orders, bad frees, merges, extremes
        alloc_block(0, 0);
        alloc_block(15, 4095);
        issue(bpa_pkg::FUNC_FREE, 10, 0);
        issue(bpa_pkg::FUNC_FREE, 15, 4095);
        issue(bpa_pkg::FUNC_FREE, 1, 1);
        issue(bpa_pkg::FUNC_FREE, 9, 256);
        free_held(0);
        free_held(0);
        free_held(0);
        free_held(0);
        free_held(held_page.size() - 1);
        alloc_block(0, 4095);
        alloc_block(1, 0);
        alloc_block(9, 0);
        alloc_block(9, 0);
        alloc_block(10, 0);
        free_held(held_page.size() - 1);
        free_held(held_page.size() - 1);
        drain();

        // Random phases, each opening with a write of both registers
        for (int ph = 0; ph < 7; ph++)
        begin
            reg_write(REG_LWM, lwm_set[ph]);
            reg_write(REG_ZONE, zone_set[ph]);
            quiet = (ph == 6);
            for (int n = 0; n < 155; n++)
                random_cmd();
            drain();
        end

        if (fails == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
